FILE: rtl/core/bipc_pkg.sv
// Shared types and constants for the binary isolated pixel cleanup core.
// Used by bipc_stage and binary_isolated_pixel_cleanup_core; no dependencies.
`default_nettype none

package bipc_pkg;

  // Field widths fixed by the stream and register formats.
  localparam int PIX_W    = 8;
  localparam int WIDTH_W  = 10;
  localparam int HEIGHT_W = 9;
  localparam int CFG_W    = 10;

  // Default line length held by each line memory.
  localparam int MAX_WIDTH_DEF = 640;

  // Register reset values.
  localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RST  = 10'd160;
  localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = 9'd120;

  // Register indexes.
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // Kind of an input word, carried on tuser.
  localparam logic OP_PIXEL = 1'b0;

  // Binary pixel levels.
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

  // Output queue depth.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  // Word presented to a stage.
  typedef struct packed {
    logic             go;      // a word enters the stage this cycle
    logic             arrive;  // the word carries a pixel (else it drains)
    logic [PIX_W-1:0] pix;
  } stg_in_t;

  // What a stage hands on in the cycle after a word entered it.
  typedef struct packed {
    logic             item;    // a word sits in the settle stage
    logic             set;     // that word settled a pixel
    logic             last;    // settled pixel closes the frame
    logic [PIX_W-1:0] pix;     // settled pixel value
  } stg_out_t;

  // Entry of the output queue.
  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] pix;
  } out_word_t;

endpackage

`default_nettype wire

FILE: rtl/core/binary_isolated_pixel_cleanup_core.sv
// Isolated pixel cleanup: hole filling stage, then speck removal stage.
// Throughput is one word per cycle while s_axis_tready is high; each stage writes its line
// memory once a cycle and reads two columns. A pixel settles when the pixel below it
// enters; results trail input by two rows plus the stage A settle, stage B settle and output
// queue registers; last rows leave on drain words. Reset clears positions, queue and
// registers (160 x 120); line memories are not cleared. Depends on bipc_pkg and bipc_stage.
`default_nettype none

module binary_isolated_pixel_cleanup_core #(
  parameter int MAX_WIDTH = bipc_pkg::MAX_WIDTH_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Configuration write port.
  input  wire                          cfg_we_i,
  input  wire                          cfg_idx_i,
  input  wire  [bipc_pkg::CFG_W-1:0]   cfg_data_i,
  // Input stream.
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [bipc_pkg::PIX_W-1:0]   s_axis_tdata,   // [7:0] pixel_in
  input  wire                          s_axis_tuser,   // [0] op
  // Output stream.
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [bipc_pkg::PIX_W-1:0]   m_axis_tdata,   // [7:0] pixel_out
  output logic                         m_axis_tlast    // frame_end
);
  import bipc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // Frame size registers.
  logic [WIDTH_W-1:0]  width_q, width_d;
  logic [HEIGHT_W-1:0] height_q, height_d;
  logic [31:0]         fw_ext;
  logic [CW-1:0]       wm1;
  logic [HEIGHT_W-1:0] hm1;

  stg_in_t  a_in, b_in;
  stg_out_t a_out, b_out;

  // Output queue.
  out_word_t         fifo_q [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_AW:0]   cnt_q, cnt_d;
  logic              push, pop;
  logic [OUT_AW+1:0] occupied;

  // Register writes.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  width_d  = cfg_data_i[WIDTH_W-1:0];
        CFG_FRAME_HEIGHT: height_d = cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective last column and last row.
  always_comb begin
    fw_ext = 32'(width_q);
    if (width_q == '0) begin
      wm1 = '0;
    end else if (fw_ext > 32'(MAX_WIDTH)) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(fw_ext - 32'd1);
    end
    hm1 = (height_q == '0) ? '0 : height_q - HEIGHT_W'(1);
  end

  // Stage A fills black holes, stage B clears white specks.
  always_comb begin
    a_in.go     = s_axis_tvalid && s_axis_tready;
    a_in.arrive = (s_axis_tuser == OP_PIXEL);
    a_in.pix    = s_axis_tdata;
    b_in.go     = a_out.item;
    b_in.arrive = a_out.set;
    b_in.pix    = a_out.pix;
  end

  bipc_stage #(.MaxWidth(MAX_WIDTH)) u_stage_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .hole_i    (PIX_BLACK),
    .wm1_i     (wm1),
    .hm1_i     (hm1),
    .in_i      (a_in),
    .out_o     (a_out)
  );

  bipc_stage #(.MaxWidth(MAX_WIDTH)) u_stage_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .hole_i    (PIX_WHITE),
    .wm1_i     (wm1),
    .hm1_i     (hm1),
    .in_i      (b_in),
    .out_o     (b_out)
  );

  // Credit check: queue entries plus words still in flight.
  assign occupied = (OUT_AW+2)'(cnt_q) + (OUT_AW+2)'(a_out.item) + (OUT_AW+2)'(b_out.item);
  assign s_axis_tready = occupied < (OUT_AW+2)'(OUT_DEPTH);

  assign push = b_out.item && b_out.set;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + (OUT_AW+1)'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - (OUT_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{last: b_out.last, pix: b_out.pix};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      cnt_q    <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + OUT_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_AW'(1);
      end
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = fifo_q[rd_ptr_q].pix;
  assign m_axis_tlast  = fifo_q[rd_ptr_q].last;

endmodule

`default_nettype wire

FILE: rtl/core/bipc_stage.sv
// One cleanup stage: fills isolated hole-level pixels with ~hole using a line
// memory holding raw and settled pixels per column. Depends on bipc_pkg.
`default_nettype none

module bipc_stage #(
  parameter int MaxWidth = bipc_pkg::MAX_WIDTH_DEF,
  localparam int CW = $clog2(MaxWidth)
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            restart_i,
  input  wire  [bipc_pkg::PIX_W-1:0]     hole_i,
  input  wire  [CW-1:0]                  wm1_i,
  input  wire  [bipc_pkg::HEIGHT_W-1:0]  hm1_i,
  input  bipc_pkg::stg_in_t              in_i,
  output bipc_pkg::stg_out_t             out_o
);
  import bipc_pkg::*;

  // Position of the next pixel and the pending last-row column.
  logic [CW-1:0]       col_q, col_d;
  logic [HEIGHT_W-1:0] row_q, row_d;
  logic                tl_vld_q, tl_vld_d;
  logic [CW-1:0]       tl_pos_q, tl_pos_d;
  logic [PIX_W-1:0]    left_q, left_d;

  // Entry decode.
  logic          at_tail, settle, vok, hok, tail_take, last;
  logic [CW-1:0] x, x1;

  // Settle stage registers.
  logic             s1_go_q, s1_ar_q, s1_set_q, s1_hok_q, s1_vok_q, s1_last_q;
  logic [CW-1:0]    s1_x_q;
  logic [PIX_W-1:0] s1_pix_q;

  // Line memory: lane 0 raw pixel, lane 1 settled pixel.
  logic [1:0][PIX_W-1:0] line_mem [MaxWidth];
  logic [1:0][PIX_W-1:0] rd0_q;
  logic [PIX_W-1:0]      rd1_q;

  // Forwarding of the write that lands on the same edge as a read.
  logic             fw_raw0_q, fw_done0_q, fw_raw1_q;
  logic             fw_raw0_d, fw_done0_d, fw_raw1_d;
  logic [PIX_W-1:0] fw_raw_q, fw_done_q;

  logic             wr_raw, wr_done;
  logic [PIX_W-1:0] fill, raw_x, raw_x1, done_x, v_h, settle_v;
  logic             h_hit, v_hit;

  // Decode which column the entering word settles, if any.
  always_comb begin
    at_tail = tl_vld_q && (col_q == tl_pos_q);
    if (in_i.arrive) begin
      x         = col_q;
      settle    = (row_q != '0) || at_tail;
      vok       = row_q > HEIGHT_W'(1);
      tail_take = (row_q == '0) && at_tail;
    end else begin
      x         = tl_pos_q;
      settle    = tl_vld_q;
      vok       = 1'b0;
      tail_take = tl_vld_q;
    end
    last = tail_take && (x == wm1_i);
    hok  = (x != '0) && (x != wm1_i);
    x1   = (x == wm1_i) ? x : x + CW'(1);
  end

  // Raster position and last-row tracking.
  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    tl_vld_d = tl_vld_q;
    tl_pos_d = tl_pos_q;
    if (restart_i) begin
      col_d    = '0;
      row_d    = '0;
      tl_vld_d = 1'b0;
      tl_pos_d = '0;
    end else if (in_i.go) begin
      if (tail_take) begin
        if (tl_pos_q == wm1_i) begin
          tl_vld_d = 1'b0;
        end else begin
          tl_pos_d = tl_pos_q + CW'(1);
        end
      end
      if (in_i.arrive) begin
        if (col_q == wm1_i) begin
          col_d = '0;
          if (row_q == hm1_i) begin
            row_d    = '0;
            tl_vld_d = 1'b1;
            tl_pos_d = '0;
          end else begin
            row_d = row_q + HEIGHT_W'(1);
          end
        end else begin
          col_d = col_q + CW'(1);
        end
      end
    end
  end

  // Write-back of the word in the settle stage, and its forwarding.
  assign wr_raw  = s1_go_q && s1_ar_q;
  assign wr_done = s1_go_q && s1_set_q;

  always_comb begin
    fw_raw0_d  = wr_raw && (s1_x_q == x);
    fw_done0_d = wr_done && (s1_x_q == x);
    fw_raw1_d  = wr_raw && (s1_x_q == x1);
  end

  // Settle: horizontal test first, then vertical on the result.
  always_comb begin
    fill   = ~hole_i;
    raw_x  = fw_raw0_q ? fw_raw_q : rd0_q[0];
    done_x = fw_done0_q ? fw_done_q : rd0_q[1];
    raw_x1 = fw_raw1_q ? fw_raw_q : rd1_q;
    h_hit  = s1_hok_q && (left_q == fill) && (raw_x == hole_i) && (raw_x1 == fill);
    v_h    = h_hit ? fill : raw_x;
    v_hit  = s1_vok_q && (done_x == fill) && (v_h == hole_i) && (s1_pix_q == fill);
    settle_v = v_hit ? fill : v_h;
  end

  always_comb begin
    if (restart_i) begin
      left_d = '0;
    end else if (wr_done) begin
      left_d = settle_v;
    end else begin
      left_d = left_q;
    end
  end

  // Line memory with one write and two reads per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_raw) begin
      line_mem[s1_x_q][0] <= s1_pix_q;
    end
    if (wr_done) begin
      line_mem[s1_x_q][1] <= settle_v;
    end
    rd0_q <= line_mem[x];
    rd1_q <= line_mem[x1][0];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      tl_vld_q   <= 1'b0;
      tl_pos_q   <= '0;
      left_q     <= '0;
      s1_go_q    <= 1'b0;
      fw_raw0_q  <= 1'b0;
      fw_done0_q <= 1'b0;
      fw_raw1_q  <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      tl_vld_q   <= tl_vld_d;
      tl_pos_q   <= tl_pos_d;
      left_q     <= left_d;
      s1_go_q    <= in_i.go;
      fw_raw0_q  <= fw_raw0_d;
      fw_done0_q <= fw_done0_d;
      fw_raw1_q  <= fw_raw1_d;
    end
  end

  // Settle stage payload.
  always_ff @(posedge clk_i) begin
    s1_ar_q   <= in_i.arrive;
    s1_set_q  <= settle;
    s1_hok_q  <= hok;
    s1_vok_q  <= vok;
    s1_last_q <= last;
    s1_x_q    <= x;
    s1_pix_q  <= in_i.pix;
    fw_raw_q  <= s1_pix_q;
    fw_done_q <= settle_v;
  end

  assign out_o.item = s1_go_q;
  assign out_o.set  = s1_set_q;
  assign out_o.last = s1_last_q;
  assign out_o.pix  = settle_v;

endmodule

`default_nettype wire

FILE: tb/binary_isolated_pixel_cleanup_core_tb.sv
// Self-checking testbench for binary_isolated_pixel_cleanup_core: a directed table, then random
// frames with idling on both stream sides, checked word by word against a line-buffer predictor.
// Depends on bipc_pkg and the core RTL only.
`default_nettype none

module binary_isolated_pixel_cleanup_core_tb;
  import bipc_pkg::*;

  localparam int       LINE_MAX      = MAX_WIDTH_DEF;
  localparam logic     OP_DRAIN      = ~OP_PIXEL;
  localparam int       SETTLE_CYCLES = 8;
  localparam int       STALL_LIMIT   = 4000;
  localparam int       PIXEL_TARGET  = 1300;
  localparam int       SHOWN_FAULTS  = 10;

  // How a stimulus word is checked.
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_WORD} chk_mode_e;
  typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic             idx;
    logic [CFG_W-1:0] val;
    logic             op;
    logic [PIX_W-1:0] pix;
    chk_mode_e        chk;
    out_word_t        typed;
  } dir_row_t;

  // What one cleanup stage hands on for one word.
  typedef struct packed {
    logic             got;
    logic             last;
    logic [PIX_W-1:0] pix;
  } stage_res_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic                cfg_idx_i     = CFG_FRAME_WIDTH;
  logic [CFG_W-1:0]    cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [PIX_W-1:0]    s_axis_tdata  = '0;
  logic                s_axis_tuser  = OP_PIXEL;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [PIX_W-1:0]    m_axis_tdata;
  logic                m_axis_tlast;

  binary_isolated_pixel_cleanup_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] pixel_in
    .s_axis_tuser  (s_axis_tuser),   // [0] op
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] pixel_out
    .m_axis_tlast  (m_axis_tlast)    // frame_end
  );

  // Predictor state: stage 0 fills holes, stage 1 clears specks.
  logic [WIDTH_W-1:0]  frame_w = FRAME_WIDTH_RST;
  logic [HEIGHT_W-1:0] frame_h = FRAME_HEIGHT_RST;
  logic [PIX_W-1:0]    raw_line  [2][LINE_MAX];
  logic [PIX_W-1:0]    done_line [2][LINE_MAX];
  int                  col_pos  [2] = '{0, 0};
  int                  row_pos  [2] = '{0, 0};
  int                  tail_cnt [2] = '{0, 0};
  logic [PIX_W-1:0]    left_val [2] = '{PIX_BLACK, PIX_BLACK};

  out_word_t           pending_pixels[$];
  out_word_t           head_word;
  dir_row_t            dir_rows[$];

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int fault_cnt     = 0;
  int pixel_cnt     = 0;
  int drain_cnt     = 0;
  int checked_cnt   = 0;
  int setting_cnt   = 0;
  int quiet_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Effective frame size as the block sees it.
  function automatic int width_now();
    int w;
    w = frame_w;
    if (w == 0) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  function automatic int height_now();
    return (frame_h == 0) ? 1 : int'(frame_h);
  endfunction

  // Settle column x of row y in stage s; left is settled, right and lower are raw.
  function automatic logic [PIX_W-1:0] settle_px(input int s, input int x, input int y,
                                                  input logic [PIX_W-1:0] lower,
                                                  input int w, input int h);
    logic [PIX_W-1:0] hole;
    logic [PIX_W-1:0] fill;
    logic [PIX_W-1:0] v;
    hole = (s == 0) ? PIX_BLACK : PIX_WHITE;
    fill = ~hole;
    v = raw_line[s][x];
    if (x > 0 && x + 1 < w && left_val[s] == fill && v == hole && raw_line[s][x+1] == fill)
      v = fill;
    if (y > 0 && y + 1 < h && done_line[s][x] == fill && v == hole && lower == fill)
      v = fill;
    done_line[s][x] = v;
    left_val[s] = v;
    return v;
  endfunction

  // A pixel enters stage s; it settles the pixel above it or a held last-row pixel.
  function automatic stage_res_t stage_arrive(input int s, input logic [PIX_W-1:0] px);
    stage_res_t res;
    int w;
    int h;
    int c;
    int r;
    res = '0;
    w = width_now();
    h = height_now();
    c = col_pos[s];
    r = row_pos[s];
    if (c >= w || r >= h) begin
      c = 0;
      r = 0;
    end
    if (r > 0) begin
      res.pix = settle_px(s, c, r - 1, px, w, h);
      res.got = 1'b1;
    end else if (tail_cnt[s] > 0 && tail_cnt[s] <= w && c == w - tail_cnt[s]) begin
      res.pix  = settle_px(s, c, h - 1, PIX_BLACK, w, h);
      res.last = (c == w - 1);
      res.got  = 1'b1;
      tail_cnt[s]--;
    end
    raw_line[s][c] = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) begin
        r = 0;
        tail_cnt[s] = w;
      end
    end
    col_pos[s] = c;
    row_pos[s] = r;
    return res;
  endfunction

  // Stage s settles one held last-row pixel, if any.
  function automatic stage_res_t stage_drain(input int s);
    stage_res_t res;
    int w;
    int h;
    int c;
    res = '0;
    w = width_now();
    h = height_now();
    if (tail_cnt[s] == 0 || tail_cnt[s] > w) begin
      tail_cnt[s] = 0;
      return res;
    end
    c = w - tail_cnt[s];
    res.pix  = settle_px(s, c, h - 1, PIX_BLACK, w, h);
    res.last = (c == w - 1);
    res.got  = 1'b1;
    tail_cnt[s]--;
    return res;
  endfunction

  // Both stages for one accepted input word; stage 1 drains when stage 0 gives nothing.
  function automatic stage_res_t cleanup_step(input logic op, input logic [PIX_W-1:0] px);
    stage_res_t fill_res;
    fill_res = (op == OP_PIXEL) ? stage_arrive(0, px) : stage_drain(0);
    if (fill_res.got) return stage_arrive(1, fill_res.pix);
    return stage_drain(1);
  endfunction

  // Mostly binary levels so that holes and specks actually occur.
  function automatic logic [PIX_W-1:0] rand_pixel();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return PIX_WHITE;
    if (pick < 88) return PIX_BLACK;
    return PIX_W'($urandom_range(255));
  endfunction

  function automatic dir_row_t write_row(input logic idx, input logic [CFG_W-1:0] val);
    dir_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.val  = val;
    return row;
  endfunction

  function automatic dir_row_t word_row(input logic op, input logic [PIX_W-1:0] pix,
                                        input chk_mode_e chk,
                                        input logic [PIX_W-1:0] want_pix,
                                        input logic want_last);
    dir_row_t row;
    row = '0;
    row.kind       = ROW_WORD;
    row.op         = op;
    row.pix        = pix;
    row.chk        = chk;
    row.typed.pix  = want_pix;
    row.typed.last = want_last;
    return row;
  endfunction

  task automatic log_fault(input string what);
    fault_cnt++;
    if (fault_cnt <= SHOWN_FAULTS) $display("mismatch: %s", what);
  endtask

  // Offer one word, with random idle cycles ahead of it, and record what it should give.
  task automatic send_word(input logic op, input logic [PIX_W-1:0] pix,
                           input chk_mode_e chk, input out_word_t typed);
    stage_res_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    res = cleanup_step(op, pix);
    case (chk)
      CHK_MODEL: if (res.got) pending_pixels.push_back({res.last, res.pix});
      CHK_WORD:  pending_pixels.push_back(typed);
      default:   ;
    endcase
    if (op == OP_PIXEL) pixel_cnt++;
    else drain_cnt++;
  endtask

  task automatic send_random(input logic op);
    send_word(op, rand_pixel(), CHK_MODEL, '0);
  endtask

  // Stop offering words and let every expected word and the pipeline tail come out.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write; every write restarts both stages and drops held pixels.
  task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) frame_w = val[WIDTH_W-1:0];
    else frame_h = val[HEIGHT_W-1:0];
    col_pos  = '{0, 0};
    row_pos  = '{0, 0};
    tail_cnt = '{0, 0};
    left_val = '{PIX_BLACK, PIX_BLACK};
    @(posedge clk_i);
  endtask

  // Output side: random stalls, and each accepted word against the oldest expectation.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        log_fault($sformatf("unexpected word pixel=%0d last=%0b", m_axis_tdata, m_axis_tlast));
      end else begin
        head_word = pending_pixels.pop_front();
        checked_cnt++;
        if (m_axis_tdata !== head_word.pix || m_axis_tlast !== head_word.last)
          log_fault($sformatf("word %0d: expected pixel=%0d last=%0b, got pixel=%0d last=%0b",
                              checked_cnt, head_word.pix, head_word.last,
                              m_axis_tdata, m_axis_tlast));
      end
    end
  end

  // Watchdog on cycles in which nothing moves on any port.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("FAIL binary_isolated_pixel_cleanup_core");
      $finish;
    end
  end

  initial begin
    int seg;
    int n;
    int sel;
    int w_eff;
    int h_eff;
    int total;
    int stop_at;
    logic [CFG_W-1:0] wv;
    logic [CFG_W-1:0] hv;

    // Reset defaults: the first pixel of a 160 x 120 frame settles nothing.
    dir_rows.push_back(word_row(OP_PIXEL, PIX_BLACK, CHK_NONE, PIX_BLACK, 1'b0));
    // Zero sizes act as a 1 x 1 frame: results trail by two words, drains empty both stages.
    dir_rows.push_back(write_row(CFG_FRAME_WIDTH, '0));
    dir_rows.push_back(write_row(CFG_FRAME_HEIGHT, '0));
    dir_rows.push_back(word_row(OP_PIXEL, PIX_BLACK, CHK_NONE, PIX_BLACK, 1'b0));
    dir_rows.push_back(word_row(OP_PIXEL, PIX_WHITE, CHK_NONE, PIX_BLACK, 1'b0));
    dir_rows.push_back(word_row(OP_PIXEL, 8'd1, CHK_WORD, PIX_BLACK, 1'b1));
    dir_rows.push_back(word_row(OP_DRAIN, PIX_BLACK, CHK_WORD, PIX_WHITE, 1'b1));
    dir_rows.push_back(word_row(OP_DRAIN, PIX_BLACK, CHK_WORD, 8'd1, 1'b1));
    dir_rows.push_back(word_row(OP_DRAIN, PIX_BLACK, CHK_NONE, PIX_BLACK, 1'b0));
    // A 3 x 3 frame with a horizontal hole, a speck and gray pass-through values.
    dir_rows.push_back(write_row(CFG_FRAME_WIDTH, 10'd3));
    dir_rows.push_back(write_row(CFG_FRAME_HEIGHT, 10'd3));
    dir_rows.push_back(word_row(OP_PIXEL, PIX_WHITE, CHK_MODEL, PIX_BLACK, 1'b0));
    dir_rows.push_back(word_row(OP_PIXEL, PIX_BLACK, CHK_MODEL, PIX_BLACK, 1'b0));
    dir_rows.push_back(word_row(OP_PIXEL, PIX_WHITE, CHK_MODEL, PIX_BLACK, 1'b0));
    dir_rows.push_back(word_row(OP_PIXEL, PIX_BLACK, CHK_MODEL, PIX_BLACK, 1'b0));
    dir_rows.push_back(word_row(OP_PIXEL, PIX_WHITE, CHK_MODEL, PIX_BLACK, 1'b0));
    dir_rows.push_back(word_row(OP_PIXEL, PIX_BLACK, CHK_MODEL, PIX_BLACK, 1'b0));
    dir_rows.push_back(word_row(OP_PIXEL, 8'd128, CHK_MODEL, PIX_BLACK, 1'b0));
    dir_rows.push_back(word_row(OP_PIXEL, PIX_BLACK, CHK_MODEL, PIX_BLACK, 1'b0));
    dir_rows.push_back(word_row(OP_PIXEL, 8'd254, CHK_MODEL, PIX_BLACK, 1'b0));
    repeat (6) dir_rows.push_back(word_row(OP_DRAIN, PIX_BLACK, CHK_MODEL, PIX_BLACK, 1'b0));

    // Reset held from the start, then released on a rising edge.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part without idling.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        quiesce();
        cfg_write(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_word(dir_rows[i].op, dir_rows[i].pix, dir_rows[i].chk, dir_rows[i].typed);
      end
    end

    // Random part: each segment picks an idling mode and a frame size.
    seg = 0;
    while (pixel_cnt < PIXEL_TARGET || seg < 8) begin
      quiesce();
      case (seg % 4)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 67; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 67; end
        default: begin src_idle_pct = 20; snk_stall_pct = 20; end
      endcase

      if (seg == 2) begin
        // Oversized width acts as a full line: the wrap into row one proves the clamp.
        cfg_write(CFG_FRAME_WIDTH, 10'h3FF);
        cfg_write(CFG_FRAME_HEIGHT, 10'd480);
        stop_at = LINE_MAX + $urandom_range(10, 40);
        for (n = 0; n < stop_at; n++) send_random(OP_PIXEL);
        quiesce();
        cfg_write(CFG_FRAME_HEIGHT, 10'd511);
        cfg_write(CFG_FRAME_WIDTH, 10'd640);
        repeat (4) send_random(OP_PIXEL);
        setting_cnt += 2;
      end else begin
        sel = $urandom_range(9);
        wv = (sel == 0) ? '0 : (sel < 4) ? CFG_W'($urandom_range(1, 3))
                                         : CFG_W'($urandom_range(4, 12));
        sel = $urandom_range(9);
        hv = (sel == 0) ? '0 : (sel < 4) ? CFG_W'($urandom_range(1, 2))
                                         : CFG_W'($urandom_range(3, 6));
        if ($urandom_range(1)) begin
          cfg_write(CFG_FRAME_WIDTH, wv);
          cfg_write(CFG_FRAME_HEIGHT, hv);
        end else begin
          cfg_write(CFG_FRAME_HEIGHT, hv);
          cfg_write(CFG_FRAME_WIDTH, wv);
        end
        setting_cnt++;
        w_eff = (wv == 0) ? 1 : int'(wv);
        h_eff = (hv == 0) ? 1 : int'(hv);
        total = $urandom_range(1, 3) * w_eff * h_eff;
        // Now and then a frame is cut short and the next write drops what is held.
        stop_at = ($urandom_range(9) == 0) ? $urandom_range(1, total) : total;
        if ($urandom_range(3) == 0) send_random(OP_DRAIN);
        for (n = 0; n < stop_at; n++) begin
          if ($urandom_range(99) < 6) send_random(OP_DRAIN);
          send_random(OP_PIXEL);
        end
        if (stop_at == total) begin
          for (n = 0; n < 2 * w_eff + 2; n++) send_random(OP_DRAIN);
        end
      end
      seg++;
    end

    // Let the last expected words and the pipeline tail come out.
    quiesce();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_pixels.size() != 0)
      log_fault($sformatf("%0d expected words never arrived", pending_pixels.size()));

    $display("Ran %0d pixel and %0d drain words over %0d random frame settings,",
             pixel_cnt, drain_cnt, setting_cnt);
    $display("with four idling modes; %0d cleaned words checked, %0d mismatches.",
             checked_cnt, fault_cnt);
    if (fault_cnt == 0) begin
      $display("PASS binary_isolated_pixel_cleanup_core");
    end else begin
      $display("FAIL binary_isolated_pixel_cleanup_core");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/bipc_pkg.sv
rtl/core/bipc_stage.sv
rtl/core/binary_isolated_pixel_cleanup_core.sv
tb/binary_isolated_pixel_cleanup_core_tb.sv
